// File: hw/rtl/tlt_pkg.sv
// Shared types, token codes and character helpers for the toy language tokenizer.
`default_nettype none

package tlt_pkg;

  // Default counter widths
  localparam int LINE_W_DEF = 16;
  localparam int POS_W_DEF  = 16;
  localparam int LEN_W_DEF  = 8;

  // Result field widths
  localparam int KIND_FW = 4;
  localparam int LINE_FW = 16;
  localparam int POS_FW  = 16;
  localparam int LEN_FW  = 8;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [KIND_FW-1:0] K_EOF     = 4'd0;
  localparam logic [KIND_FW-1:0] K_DOLLAR  = 4'd1;
  localparam logic [KIND_FW-1:0] K_LPAREN  = 4'd2;
  localparam logic [KIND_FW-1:0] K_RPAREN  = 4'd3;
  localparam logic [KIND_FW-1:0] K_EQUAL   = 4'd4;
  localparam logic [KIND_FW-1:0] K_QUOTE   = 4'd5;
  localparam logic [KIND_FW-1:0] K_DQUOTE  = 4'd6;
  localparam logic [KIND_FW-1:0] K_NAME    = 4'd7;
  localparam logic [KIND_FW-1:0] K_PRINT   = 4'd8;
  localparam logic [KIND_FW-1:0] K_IGNORED = 4'd9;
  localparam logic [KIND_FW-1:0] K_ERROR   = 4'd10;

  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_VT         = 8'h0B;
  localparam logic [7:0] CH_FF         = 8'h0C;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;

  // Keyword match progress
  localparam logic [2:0] KW_START = 3'd0;
  localparam logic [2:0] KW_DONE  = 3'd5;
  localparam logic [2:0] KW_MISS  = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [KIND_FW-1:0] token_kind;
    logic [LINE_FW-1:0] line_number;
    logic [POS_FW-1:0]  token_start;
    logic [LEN_FW-1:0]  token_length;
    logic               last_of_run;
  } out_item_t;

  // One queue entry holds all tokens caused by one item
  typedef struct packed {
    logic      two;
    out_item_t tok0;
    out_item_t tok1;
  } q_entry_t;

  typedef struct packed {
    logic     empty;
    q_entry_t head;
  } q_rd_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) || (b == CH_FF) ||
           (b == CH_CR) || (b == CH_SPACE);
  endfunction

  // "print"
  function automatic logic [7:0] kw_char(input logic [2:0] prog);
    logic [7:0] c;
    case (prog)
      3'd0: c = 8'h70;
      3'd1: c = 8'h72;
      3'd2: c = 8'h69;
      3'd3: c = 8'h6E;
      3'd4: c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_step(input logic [2:0] prog, input logic idx_match,
                                         input logic [7:0] b);
    logic [2:0] r;
    r = KW_MISS;
    if ((prog < KW_DONE) && idx_match && (b == kw_char(prog))) begin
      r = prog + 3'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tlt_front.sv
// Tokenizer front end: accepts bytes, tracks lexer state, queues the tokens of each item.
`default_nettype none

module tlt_front import tlt_pkg::*; #(
  parameter int LINE_WIDTH = LINE_W_DEF,
  parameter int POS_WIDTH  = POS_W_DEF,
  parameter int LEN_WIDTH  = LEN_W_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          q_push,
  output q_entry_t      q_data
);

  typedef enum logic [3:0] {
    PEND_NONE  = 4'b0001,
    PEND_SPACE = 4'b0010,
    PEND_NAME  = 4'b0100,
    PEND_QUOTE = 4'b1000
  } pend_t;

  typedef enum logic [2:0] {
    NL_NONE = 3'b001,
    NL_CR   = 3'b010,
    NL_LF   = 3'b100
  } nl_t;

  pend_t                pend_r, pend_nxt;
  nl_t                  nl_r, nl_nxt;
  logic [LINE_WIDTH-1:0] line_r, line_nxt;
  logic [POS_WIDTH-1:0]  pos_r, pos_nxt;
  logic [POS_WIDTH-1:0]  start_r, start_nxt;
  logic [LEN_WIDTH-1:0]  len_r, len_nxt;
  logic [2:0]            kw_r, kw_nxt;
  logic                  halted_r, halted_nxt;

  logic                  accept;
  logic [7:0]            b;
  logic                  name_ch;
  logic [LINE_WIDTH-1:0] line_inc;
  logic [POS_WIDTH-1:0]  pos_inc;
  logic [LEN_WIDTH-1:0]  len_inc;
  logic                  do_flush;
  logic                  fl_emit;
  logic                  sec_has;
  out_item_t             fl_tok;
  out_item_t             sec_tok;
  nl_t                   mine;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    b        = in_item.data_byte;
    name_ch  = is_letter(b) || is_digit(b) || (b == CH_UNDERSCORE);
    line_inc = (line_r == '1) ? line_r : line_r + 1'b1;
    pos_inc  = (pos_r == '1) ? pos_r : pos_r + 1'b1;
    len_inc  = (len_r == '1) ? len_r : len_r + 1'b1;
    mine     = (b == CH_CR) ? NL_CR : NL_LF;

    fl_tok              = '0;
    fl_tok.line_number  = LINE_FW'(line_r);
    fl_tok.token_start  = POS_FW'(start_r);
    fl_tok.token_length = LEN_FW'(len_r);
    case (pend_r)
      PEND_SPACE: begin
        fl_tok.token_kind = K_IGNORED;
      end
      PEND_NAME: begin
        fl_tok.token_kind = (kw_r == KW_DONE) ? K_PRINT : K_NAME;
      end
      PEND_QUOTE: begin
        fl_tok.token_kind   = K_QUOTE;
        fl_tok.token_length = LEN_FW'(1);
      end
      default: begin
        fl_tok.token_kind = K_EOF;
      end
    endcase

    sec_tok              = '0;
    sec_tok.line_number  = LINE_FW'(line_r);
    sec_tok.token_start  = POS_FW'(pos_r);
    sec_tok.token_length = LEN_FW'(1);
    sec_tok.token_kind   = K_EOF;

    pend_nxt   = pend_r;
    nl_nxt     = nl_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    kw_nxt     = kw_r;
    halted_nxt = halted_r;
    do_flush   = 1'b0;
    sec_has    = 1'b0;

    if (accept && !halted_r) begin
      if (in_item.end_of_input) begin
        do_flush             = 1'b1;
        pend_nxt             = PEND_NONE;
        len_nxt              = '0;
        kw_nxt               = KW_START;
        sec_has              = 1'b1;
        sec_tok.token_kind   = K_EOF;
        sec_tok.token_length = '0;
        nl_nxt               = NL_NONE;
      end else begin
        pos_nxt = pos_inc;
        if ((pend_r == PEND_QUOTE) && (b == CH_DQUOTE)) begin
          sec_has              = 1'b1;
          sec_tok.token_kind   = K_DQUOTE;
          sec_tok.token_start  = POS_FW'(start_r);
          sec_tok.token_length = LEN_FW'(2);
          pend_nxt             = PEND_NONE;
          nl_nxt               = NL_NONE;
        end else if ((pend_r == PEND_NAME) && name_ch) begin
          kw_nxt  = kw_step(kw_r, len_r == LEN_WIDTH'(kw_r), b);
          len_nxt = len_inc;
        end else if (is_space(b)) begin
          if (pend_r == PEND_SPACE) begin
            len_nxt = len_inc;
          end else begin
            do_flush  = 1'b1;
            kw_nxt    = KW_START;
            pend_nxt  = PEND_SPACE;
            start_nxt = pos_r;
            len_nxt   = LEN_WIDTH'(1);
          end
          if ((b == CH_CR) || (b == CH_LF)) begin
            if ((nl_r != NL_NONE) && (nl_r != mine)) begin
              nl_nxt = NL_NONE;
            end else begin
              line_nxt = line_inc;
              nl_nxt   = mine;
            end
          end else begin
            nl_nxt = NL_NONE;
          end
        end else begin
          do_flush = 1'b1;
          pend_nxt = PEND_NONE;
          len_nxt  = '0;
          kw_nxt   = KW_START;
          nl_nxt   = NL_NONE;
          case (b)
            CH_DOLLAR: begin
              sec_has            = 1'b1;
              sec_tok.token_kind = K_DOLLAR;
            end
            CH_LPAREN: begin
              sec_has            = 1'b1;
              sec_tok.token_kind = K_LPAREN;
            end
            CH_RPAREN: begin
              sec_has            = 1'b1;
              sec_tok.token_kind = K_RPAREN;
            end
            CH_EQUAL: begin
              sec_has            = 1'b1;
              sec_tok.token_kind = K_EQUAL;
            end
            CH_DQUOTE: begin
              pend_nxt  = PEND_QUOTE;
              start_nxt = pos_r;
              len_nxt   = LEN_WIDTH'(1);
            end
            default: begin
              if (is_letter(b) || (b == CH_UNDERSCORE)) begin
                pend_nxt  = PEND_NAME;
                start_nxt = pos_r;
                len_nxt   = LEN_WIDTH'(1);
                kw_nxt    = kw_step(KW_START, 1'b1, b);
              end else begin
                sec_has            = 1'b1;
                sec_tok.token_kind = K_ERROR;
                halted_nxt         = 1'b1;
              end
            end
          endcase
        end
      end
    end

    fl_emit = do_flush && (pend_r != PEND_NONE);
    q_push  = fl_emit || sec_has;

    q_data                  = '0;
    q_data.two              = fl_emit && sec_has;
    q_data.tok0             = fl_emit ? fl_tok : sec_tok;
    q_data.tok0.last_of_run = !(fl_emit && sec_has);
    q_data.tok1             = sec_tok;
    q_data.tok1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= PEND_NONE;
      nl_r     <= NL_NONE;
      line_r   <= LINE_WIDTH'(1);
      pos_r    <= '0;
      start_r  <= '0;
      len_r    <= '0;
      kw_r     <= KW_START;
      halted_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      nl_r     <= nl_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      kw_r     <= kw_nxt;
      halted_r <= halted_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt released without reset");

  a_no_push_halted: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !q_push)
    else $error("token queued after halt");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/tlt_queue.sv
// Short item queue between tokenizer front and back ends.
`default_nettype none

module tlt_queue import tlt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  input  wire logic     pop,
  output logic          full,
  output q_rd_t         rd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign rd.empty = (count_r == '0);
  assign rd.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd.empty |-> !pop)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/tlt_back.sv
// Tokenizer back end: splits queued items into tokens and drives the output register.
`default_nettype none

module tlt_back import tlt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire q_rd_t rd,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_item
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      sel_r, sel_nxt;
  logic      load;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    load          = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    sel_nxt       = sel_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = !rd.empty;
      out_item_nxt  = sel_r ? rd.head.tok1 : rd.head.tok0;
      if (!rd.empty) begin
        pop     = sel_r || !rd.head.two;
        sel_nxt = !sel_r && rd.head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_sel_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (!rd.empty && rd.head.two))
    else $error("second token selected without a two-token item");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/toy_language_tokenizer.sv
// Top level of the toy language tokenizer.
`default_nettype none

// Streaming tokenizer: one source byte (or end-of-input mark) is accepted per cycle
// while in_stall is low, and each item yields zero, one or two tokens with kind, line,
// start position and length; last_of_run marks the final token of an item. Tokens leave
// at one per cycle from the output register while out_stall is low; every token first
// passes through a four-item queue between the lexer front end and the output stage,
// which absorbs two-token items and output stalls, and in_stall rises only when that
// queue is full. An unexpected byte gives an error token, after which items are taken
// and dropped until reset. No clearing pass is needed after reset.
module toy_language_tokenizer import tlt_pkg::*; #(
  parameter int LINE_WIDTH = LINE_W_DEF,
  parameter int POS_WIDTH  = POS_W_DEF,
  parameter int LEN_WIDTH  = LEN_W_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic     q_full;
  logic     q_push;
  q_entry_t q_data;
  logic     q_pop;
  q_rd_t    q_rd;

  tlt_front #(
    .LINE_WIDTH (LINE_WIDTH),
    .POS_WIDTH  (POS_WIDTH),
    .LEN_WIDTH  (LEN_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  tlt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .rd        (q_rd)
  );

  tlt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (q_rd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
